@@ rtl/lpht_pkg.sv @@
package lpht_pkg;

    localparam int TS_W         = 13;
    localparam int HASH_W       = 34;
    localparam int DIV_STEPS    = 2;
    localparam int DIV_CYCLES   = HASH_W / DIV_STEPS;
    localparam int DCNT_W       = $clog2(DIV_CYCLES);

    localparam logic [TS_W-1:0] TS_RESET = 13'd4093;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [30:0] run_id;
        logic [31:0] flags;
        logic [15:0] run_index;
        logic [7:0]  service_index;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [30:0] run_id;
        logic [31:0] flags;
        logic [15:0] run_index;
        logic [7:0]  service_index;
    } slot_row_t;

endpackage

@@ rtl/lpht_front.sv @@
module lpht_front #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      cmd,
    input  logic [30:0]                     run_id,
    input  logic [31:0]                     flags,
    input  logic [15:0]                     run_index,
    input  logic [7:0]                      service_index,
    input  logic [$clog2(MAX_SLOTS):0]      n_slots,
    input  logic                            q_full,
    output logic                            q_push,
    output lpht_pkg::item_t                 q_item,
    output logic [$clog2(MAX_SLOTS)-1:0]    q_home
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int N_W   = IDX_W + 1;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t            state_reg, state_next;
    item_t              item_reg;
    logic [HASH_W-1:0]  dvd_reg, dvd_next;
    logic [N_W-1:0]     rem_reg, rem_next;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [HASH_W-1:0]  hash;
    logic               accept;

    assign in_ready = (state_reg == F_IDLE);
    assign accept   = in_valid && in_ready;
    assign hash     = ({3'b000, run_id} << 2) + {3'b000, run_id}
                      + HASH_W'(flags != 32'd0);

    // restoring remainder, a few quotient bits per cycle
    always_comb
    begin
        logic [N_W:0]      r_w;
        logic [N_W-1:0]    r;
        logic [HASH_W-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            r_w = {r, d[HASH_W-1]};
            d   = d << 1;
            if (r_w >= {1'b0, n_slots})
                r_w = r_w - {1'b0, n_slots};
            r = r_w[N_W-1:0];
        end
        rem_next = r;
        dvd_next = d;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
                if (accept)
                    state_next = (cmd == CMD_INSERT || cmd == CMD_LOOKUP) ? F_DIV : F_PUSH;
            F_DIV:
                if (dcnt_reg == DCNT_W'(DIV_CYCLES - 1))
                    state_next = F_PUSH;
            F_PUSH:
                if (!q_full)
                    state_next = F_IDLE;
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                dcnt_reg <= '0;
            else if (state_reg == F_DIV)
                dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{cmd: cmd, run_id: run_id, flags: flags,
                          run_index: run_index, service_index: service_index};
            dvd_reg  <= hash;
            rem_reg  <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_item = item_reg;
    assign q_home = rem_reg[IDX_W-1:0];

endmodule

@@ rtl/lpht_fifo.sv @@
module lpht_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);
    logic [W-1:0] mem_reg [2];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= din;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underflow");

endmodule

@@ rtl/lpht_back.sv @@
module lpht_back #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [$clog2(MAX_SLOTS):0]      n_slots,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  lpht_pkg::item_t                 q_item,
    input  logic [$clog2(MAX_SLOTS)-1:0]    q_home,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [15:0]                     found_run_index,
    output logic [7:0]                      found_service_index
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int N_W   = IDX_W + 1;

    typedef enum logic [4:0] {
        B_CLR   = 5'b00001,
        B_IDLE  = 5'b00010,
        B_PROBE = 5'b00100,
        B_CHECK = 5'b01000,
        B_DONE  = 5'b10000
    } bstate_t;

    slot_row_t          slot_mem [MAX_SLOTS];
    slot_row_t          rd_data_reg;
    bstate_t            state_reg;
    item_t              cur_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [N_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]   clr_addr_reg;
    logic               clr_reply_reg;
    logic [1:0]         res_status_reg;
    logic [15:0]        res_ri_reg;
    logic [7:0]         res_si_reg;
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [15:0]        fri_reg;
    logic [7:0]         fsi_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_row_t          wr_row;
    logic               key_match;
    logic               last_probe;
    logic [N_W-1:0]     cnt_inc;
    logic [N_W-1:0]     k_inc;
    logic [IDX_W-1:0]   k_wrap;
    logic               out_free;

    assign key_match  = (rd_data_reg.run_id == cur_reg.run_id)
                        && (rd_data_reg.flags == cur_reg.flags);
    assign cnt_inc    = cnt_reg + 1'b1;
    assign last_probe = (cnt_inc == n_slots);
    assign k_inc      = {1'b0, k_reg} + 1'b1;
    assign k_wrap     = (k_inc >= n_slots) ? '0 : k_inc[IDX_W-1:0];
    assign out_free   = !out_valid_reg || out_ready;
    assign q_pop      = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = k_reg;
        wr_row  = '{valid: 1'b1, run_id: cur_reg.run_id, flags: cur_reg.flags,
                    run_index: cur_reg.run_index, service_index: cur_reg.service_index};
        if (state_reg == B_CLR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_row  = '0;
        end
        else if (state_reg == B_CHECK && cur_reg.cmd == CMD_INSERT && !rd_data_reg.valid)
            wr_en = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_row;
        rd_data_reg <= slot_mem[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLR;
            clr_addr_reg  <= '0;
            clr_reply_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (state_reg == B_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_CLR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == IDX_W'(MAX_SLOTS - 1))
                        state_reg <= clr_reply_reg ? B_DONE : B_IDLE;
                end
                B_IDLE:
                    if (!q_empty)
                    begin
                        cnt_reg <= '0;
                        if (q_item.cmd == CMD_INSERT || q_item.cmd == CMD_LOOKUP)
                            state_reg <= B_PROBE;
                        else if (q_item.cmd == CMD_CLEAR)
                        begin
                            state_reg     <= B_CLR;
                            clr_addr_reg  <= '0;
                            clr_reply_reg <= 1'b1;
                        end
                        else
                            state_reg <= B_DONE;
                    end
                B_PROBE:
                    state_reg <= B_CHECK;
                B_CHECK:
                    if (!rd_data_reg.valid || last_probe
                        || (cur_reg.cmd == CMD_LOOKUP && key_match))
                        state_reg <= B_DONE;
                    else
                    begin
                        cnt_reg   <= cnt_inc;
                        state_reg <= B_PROBE;
                    end
                B_DONE:
                    if (out_free)
                        state_reg <= B_IDLE;
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    // payload and result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && !q_empty)
        begin
            cur_reg        <= q_item;
            k_reg          <= q_home;
            res_status_reg <= ST_OK;
            res_ri_reg     <= '0;
            res_si_reg     <= '0;
        end
        else if (state_reg == B_CHECK)
        begin
            if (cur_reg.cmd == CMD_INSERT)
            begin
                if (rd_data_reg.valid && last_probe)
                    res_status_reg <= ST_FULL;
            end
            else if (!rd_data_reg.valid || (!key_match && last_probe))
                res_status_reg <= ST_MISS;
            else if (key_match)
            begin
                res_ri_reg <= rd_data_reg.run_index;
                res_si_reg <= rd_data_reg.service_index;
            end
            k_reg <= k_wrap;
        end
        if (state_reg == B_DONE && out_free)
        begin
            status_reg <= res_status_reg;
            fri_reg    <= res_ri_reg;
            fsi_reg    <= res_si_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign status              = status_reg;
    assign found_run_index     = fri_reg;
    assign found_service_index = fsi_reg;

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PROBE) |-> ({1'b0, k_reg} < n_slots))
        else $error("probe address beyond table size");

    a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CHECK) |-> (cnt_reg < n_slots))
        else $error("probe count exceeds table size");

endmodule

@@ rtl/linear_probe_hash_table_unit.sv @@
// channel  signals                                           direction
// in       in_valid/in_ready, cmd, run_id, flags,            into block
//          run_index, service_index
// out      out_valid/out_ready, status, found_run_index,     out of block
//          found_service_index
// cfg      cfg_valid/cfg_ready, cfg_data (table_size)        into block
//
// front: takes a transaction, then computes the home-slot remainder
// (2 bits a cycle) for insert and lookup, then queues it.
// back: each probe is a memory read, then a check; the result is then delivered.
// clear: one memory row per cycle over all MAX_SLOTS rows; after reset the same
// clearing pass runs over all MAX_SLOTS rows before the first item is taken.
// a two-entry queue and the output register let either side stall alone.
module linear_probe_hash_table_unit #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [30:0] run_id,
    input  logic [31:0] flags,
    input  logic [15:0] run_index,
    input  logic [7:0]  service_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] found_run_index,
    output logic [7:0]  found_service_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int N_W   = IDX_W + 1;
    localparam int CMP_W = (N_W > TS_W) ? N_W : TS_W;
    localparam int Q_W   = $bits(item_t) + IDX_W;

    logic [TS_W-1:0]    table_size_reg;
    logic [CMP_W-1:0]   ts_ext;
    logic [N_W-1:0]     n_slots;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    item_t              f_item;
    logic [IDX_W-1:0]   f_home;
    logic [Q_W-1:0]     q_din;
    logic [Q_W-1:0]     q_dout;
    item_t              b_item;
    logic [IDX_W-1:0]   b_home;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_size_reg <= TS_RESET;
        else if (cfg_valid)
            table_size_reg <= cfg_data;
    end

    // zero acts as one, anything above the memory depth as the depth
    assign ts_ext = CMP_W'(table_size_reg);
    always_comb
    begin
        if (ts_ext == '0)
            n_slots = N_W'(1);
        else if (ts_ext > CMP_W'(MAX_SLOTS))
            n_slots = N_W'(MAX_SLOTS);
        else
            n_slots = ts_ext[N_W-1:0];
    end

    lpht_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .run_id        (run_id),
        .flags         (flags),
        .run_index     (run_index),
        .service_index (service_index),
        .n_slots       (n_slots),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (f_item),
        .q_home        (f_home)
    );

    assign q_din = {f_item, f_home};

    lpht_fifo #(.W(Q_W)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign b_item = q_dout[Q_W-1:IDX_W];
    assign b_home = q_dout[IDX_W-1:0];

    lpht_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .n_slots             (n_slots),
        .q_empty             (q_empty),
        .q_pop               (q_pop),
        .q_item              (b_item),
        .q_home              (b_home),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .status              (status),
        .found_run_index     (found_run_index),
        .found_service_index (found_service_index)
    );

endmodule
